@@ rtl/core/lps_pkg.sv @@
// Shared types and constants for the lexicographic permutation stepper.
// Holds request opcodes, register indexes, reset values and the control and
// status structs passed between the top level and the stepping core.
package lps_pkg;

  localparam int unsigned OPCODE_W  = 1;
  localparam int unsigned INDEX_W   = 4;
  localparam int unsigned VALUE_W   = 8;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned SIZE_W    = 5;
  localparam int unsigned EMIT_W    = 5;
  localparam int unsigned ADV_W     = 16;

  localparam logic [OPCODE_W-1:0] OP_LOAD    = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_ADVANCE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_IN_USE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EMIT_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADVANCE_COUNT = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET    = 5'd16;
  localparam logic [EMIT_W-1:0] EMIT_RESET    = 5'd16;
  localparam logic [ADV_W-1:0]  ADVANCE_RESET = 16'd1;

  typedef struct packed {
    logic adv_start;
    logic load_we;
    logic out_free;
  } lps_ctl_t;

  typedef struct packed {
    logic busy;
    logic emit_fire;
    logic emit_last;
    logic emit_wrap;
  } lps_sts_t;

endpackage

@@ rtl/core/lps_core.sv @@
// Stepping core: element memory, one shared comparator and the sequencer that
// emits the prefix and applies the next-permutation steps.
// Depends on lps_pkg for the control and status structs.
module lps_core #(
  parameter int unsigned MAX_ELEMENTS  = 16,
  parameter int unsigned ELEMENT_WIDTH = 8,
  parameter int unsigned IW = $clog2(MAX_ELEMENTS),
  parameter int unsigned CW = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lps_pkg::lps_ctl_t         ctl_i,
  input  logic [IW-1:0]             load_addr_i,
  input  logic [ELEMENT_WIDTH-1:0]  load_data_i,
  input  logic [CW-1:0]             n_i,
  input  logic [CW-1:0]             emit_cnt_i,
  input  logic [lps_pkg::ADV_W-1:0] adv_cnt_i,
  output lps_pkg::lps_sts_t         sts_o,
  output logic [IW-1:0]             emit_pos_o,
  output logic [ELEMENT_WIDTH-1:0]  emit_data_o
);

  typedef enum logic [12:0] {
    ST_IDLE      = 13'b0000000000001,
    ST_EMIT_RD   = 13'b0000000000010,
    ST_EMIT_WAIT = 13'b0000000000100,
    ST_STEP      = 13'b0000000001000,
    ST_PIV_RD    = 13'b0000000010000,
    ST_PIV_CMP   = 13'b0000000100000,
    ST_SUC_RD    = 13'b0000001000000,
    ST_SUC_CMP   = 13'b0000010000000,
    ST_REV_CHK   = 13'b0000100000000,
    ST_SWP_RD    = 13'b0001000000000,
    ST_SWP_W1    = 13'b0010000000000,
    ST_SWP_W2    = 13'b0100000000000,
    ST_STEP_END  = 13'b1000000000000
  } lps_state_e;

  lps_state_e state_q, state_d;

  logic [ELEMENT_WIDTH-1:0] mem_q [MAX_ELEMENTS];
  logic [ELEMENT_WIDTH-1:0] rd_a_q, rd_b_q;
  logic                     rd_en, we;
  logic [IW-1:0]            ra, rb, waddr;
  logic [ELEMENT_WIDTH-1:0] wdata;

  logic [IW-1:0] k_q, k_d, p_q, p_d, q_q, q_d, lo_q, lo_d, hi_q, hi_d;
  logic [IW-1:0] sx_q, sx_d, sy_q, sy_d;
  logic [lps_pkg::ADV_W-1:0] step_q, step_d;
  logic any_q, any_d, wrap_q, wrap_d;
  logic a_ge_b, emit_last, emit_fire;
  logic [IW-1:0] n_last;

  // The single shared comparator used by both scans.
  assign a_ge_b    = (rd_a_q >= rd_b_q);
  assign emit_last = ((32'(k_q) + 32'd1) == 32'(emit_cnt_i));
  assign n_last    = IW'(n_i - CW'(1));

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_a_q <= mem_q[ra];
      rd_b_q <= mem_q[rb];
    end
  end

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    p_d       = p_q;
    q_d       = q_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    sx_d      = sx_q;
    sy_d      = sy_q;
    step_d    = step_q;
    any_d     = any_q;
    wrap_d    = wrap_q;
    rd_en     = 1'b0;
    ra        = k_q;
    rb        = p_q;
    we        = 1'b0;
    waddr     = sx_q;
    wdata     = rd_b_q;
    emit_fire = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (ctl_i.load_we) begin
          we    = 1'b1;
          waddr = load_addr_i;
          wdata = load_data_i;
        end
        if (ctl_i.adv_start) begin
          k_d     = '0;
          state_d = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        rd_en   = 1'b1;
        ra      = k_q;
        state_d = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (ctl_i.out_free) begin
          emit_fire = 1'b1;
          if (emit_last) begin
            if (adv_cnt_i == '0) begin
              wrap_d  = 1'b0;
              state_d = ST_IDLE;
            end else begin
              step_d  = '0;
              any_d   = 1'b0;
              state_d = ST_STEP;
            end
          end else begin
            k_d     = k_q + IW'(1);
            state_d = ST_EMIT_RD;
          end
        end
      end
      ST_STEP: begin
        if (n_i < CW'(2)) begin
          any_d   = 1'b1;
          state_d = ST_STEP_END;
        end else begin
          p_d     = n_last;
          state_d = ST_PIV_RD;
        end
      end
      ST_PIV_RD: begin
        if (p_q == '0) begin
          any_d   = 1'b1;
          lo_d    = '0;
          hi_d    = n_last;
          state_d = ST_REV_CHK;
        end else begin
          rd_en   = 1'b1;
          ra      = p_q - IW'(1);
          rb      = p_q;
          state_d = ST_PIV_CMP;
        end
      end
      ST_PIV_CMP: begin
        p_d = p_q - IW'(1);
        if (a_ge_b) begin
          state_d = ST_PIV_RD;
        end else begin
          q_d     = n_last;
          state_d = ST_SUC_RD;
        end
      end
      ST_SUC_RD: begin
        rd_en   = 1'b1;
        ra      = p_q;
        rb      = q_q;
        state_d = ST_SUC_CMP;
      end
      ST_SUC_CMP: begin
        if (a_ge_b) begin
          q_d     = q_q - IW'(1);
          state_d = ST_SUC_RD;
        end else begin
          sx_d    = p_q;
          sy_d    = q_q;
          lo_d    = p_q + IW'(1);
          hi_d    = n_last;
          state_d = ST_SWP_RD;
        end
      end
      ST_REV_CHK: begin
        if (lo_q < hi_q) begin
          sx_d    = lo_q;
          sy_d    = hi_q;
          lo_d    = lo_q + IW'(1);
          hi_d    = hi_q - IW'(1);
          state_d = ST_SWP_RD;
        end else begin
          state_d = ST_STEP_END;
        end
      end
      ST_SWP_RD: begin
        rd_en   = 1'b1;
        ra      = sx_q;
        rb      = sy_q;
        state_d = ST_SWP_W1;
      end
      ST_SWP_W1: begin
        we      = 1'b1;
        waddr   = sx_q;
        wdata   = rd_b_q;
        state_d = ST_SWP_W2;
      end
      ST_SWP_W2: begin
        we      = 1'b1;
        waddr   = sy_q;
        wdata   = rd_a_q;
        state_d = ST_REV_CHK;
      end
      ST_STEP_END: begin
        if ((17'(step_q) + 17'd1) == 17'(adv_cnt_i)) begin
          wrap_d  = any_q;
          state_d = ST_IDLE;
        end else begin
          step_d  = step_q + 16'd1;
          state_d = ST_STEP;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      p_q     <= '0;
      q_q     <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      step_q  <= '0;
      any_q   <= 1'b0;
      wrap_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      p_q     <= p_d;
      q_q     <= q_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      sx_q    <= sx_d;
      sy_q    <= sy_d;
      step_q  <= step_d;
      any_q   <= any_d;
      wrap_q  <= wrap_d;
    end
  end

  assign sts_o.busy      = (state_q != ST_IDLE);
  assign sts_o.emit_fire = emit_fire;
  assign sts_o.emit_last = emit_last;
  assign sts_o.emit_wrap = emit_last && wrap_q;
  assign emit_pos_o      = k_q;
  assign emit_data_o     = rd_a_q;

endmodule

@@ rtl/core/lexicographic_permutation_stepper.sv @@
// Top level of the lexicographic permutation stepper: request and result
// channels, configuration registers and the result register.
// Depends on lps_pkg and instantiates lps_core.
//
// A request with opcode load writes value_i into element index_i
// and produces no result. A request with opcode advance first emits the
// leading emit_count elements as results, the final one marked by last_o and
// carrying in wrapped_o whether the previous advance wrapped. It then applies
// advance_count next-permutation steps to the first size_in_use elements.
// Each result is an element memory read, then the load of the result register.
// Each step scans for the pivot and then the successor with the shared
// comparator, swaps the two and reverses the suffix; a step that finds no
// pivot reverses all size_in_use elements and counts as a wrap.
// in_ready_o is low from an advance request until its last step is done.
// When the receiver stalls, the sequencer holds the next element until the
// result register is free. Reset loads the register defaults and clears the
// wrap flag; elements hold no defined value until loaded.
module lexicographic_permutation_stepper #(
  parameter int unsigned MAX_ELEMENTS  = 16,
  parameter int unsigned ELEMENT_WIDTH = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [lps_pkg::OPCODE_W-1:0]   opcode_i,
  input  logic [lps_pkg::INDEX_W-1:0]    index_i,
  input  logic [lps_pkg::VALUE_W-1:0]    value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [lps_pkg::POS_W-1:0]      position_o,
  output logic [lps_pkg::VALUE_W-1:0]    element_o,
  output logic                           last_o,
  output logic                           wrapped_o,
  input  logic                           cfg_we_i,
  input  logic [lps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lps_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

  logic [lps_pkg::SIZE_W-1:0] size_q;
  logic [lps_pkg::EMIT_W-1:0] emit_q;
  logic [lps_pkg::ADV_W-1:0]  adv_q;

  logic [CW-1:0] n_sat, emit_sat;
  logic          in_fire, idx_ok, out_free;
  logic [IW+lps_pkg::INDEX_W-1:0]      idx_ext;
  logic [ELEMENT_WIDTH+lps_pkg::VALUE_W-1:0] val_ext, el_ext;
  logic [IW+lps_pkg::POS_W-1:0]        pos_ext;

  lps_pkg::lps_ctl_t ctl;
  lps_pkg::lps_sts_t sts;
  logic [IW-1:0]            emit_pos;
  logic [ELEMENT_WIDTH-1:0] emit_data;

  logic                          out_valid_q;
  logic [lps_pkg::POS_W-1:0]     pos_q;
  logic [lps_pkg::VALUE_W-1:0]   elem_q;
  logic                          last_q, wrap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= lps_pkg::SIZE_RESET;
      emit_q <= lps_pkg::EMIT_RESET;
      adv_q  <= lps_pkg::ADVANCE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lps_pkg::CFG_SIZE_IN_USE:   size_q <= cfg_data_i[lps_pkg::SIZE_W-1:0];
        lps_pkg::CFG_EMIT_COUNT:    emit_q <= cfg_data_i[lps_pkg::EMIT_W-1:0];
        lps_pkg::CFG_ADVANCE_COUNT: adv_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(size_q) > MAX_ELEMENTS) begin
      n_sat = CW'(MAX_ELEMENTS);
    end else begin
      n_sat = CW'(size_q);
    end
    priority if (emit_q == '0) begin
      emit_sat = CW'(1);
    end else if (32'(emit_q) > MAX_ELEMENTS) begin
      emit_sat = CW'(MAX_ELEMENTS);
    end else begin
      emit_sat = CW'(emit_q);
    end
  end

  assign in_ready_o = !sts.busy;
  assign in_fire    = in_valid_i && in_ready_o;
  assign idx_ok     = (32'(index_i) < MAX_ELEMENTS);
  assign idx_ext    = {{IW{1'b0}}, index_i};
  assign val_ext    = {{ELEMENT_WIDTH{1'b0}}, value_i};
  assign out_free   = !out_valid_q || out_ready_i;

  assign ctl.adv_start = in_fire && (opcode_i == lps_pkg::OP_ADVANCE);
  assign ctl.load_we   = in_fire && (opcode_i == lps_pkg::OP_LOAD) && idx_ok;
  assign ctl.out_free  = out_free;

  lps_core #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .ELEMENT_WIDTH(ELEMENT_WIDTH),
    .IW           (IW),
    .CW           (CW)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .load_addr_i(idx_ext[IW-1:0]),
    .load_data_i(val_ext[ELEMENT_WIDTH-1:0]),
    .n_i        (n_sat),
    .emit_cnt_i (emit_sat),
    .adv_cnt_i  (adv_q),
    .sts_o      (sts),
    .emit_pos_o (emit_pos),
    .emit_data_o(emit_data)
  );

  assign pos_ext = {{lps_pkg::POS_W{1'b0}}, emit_pos};
  assign el_ext  = {{lps_pkg::VALUE_W{1'b0}}, emit_data};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sts.emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sts.emit_fire) begin
      pos_q  <= pos_ext[lps_pkg::POS_W-1:0];
      elem_q <= el_ext[lps_pkg::VALUE_W-1:0];
      last_q <= sts.emit_last;
      wrap_q <= sts.emit_wrap;
    end
  end

  assign out_valid_o = out_valid_q;
  assign position_o  = pos_q;
  assign element_o   = elem_q;
  assign last_o      = last_q;
  assign wrapped_o   = wrap_q;

  a_emit_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.emit_fire |-> out_free)
    else $error("Result issued while the result register was stalled.");

  a_advance_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.adv_start |=> sts.busy)
    else $error("Advance request did not start the sequencer.");

  a_wrap_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && wrap_q |-> last_q)
    else $error("Wrap flag shown on a result that is not the last.");

  a_no_load_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.busy |-> !ctl.load_we && !ctl.adv_start)
    else $error("Request taken while the sequencer was busy.");

endmodule

@@ tb/lexicographic_permutation_stepper_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for lexicographic_permutation_stepper: a directed table, then random
// load and advance requests under several idling patterns, each emitted prefix checked against
// a predictor of the permutation steps. Depends on lps_pkg and the stepper RTL.
module lexicographic_permutation_stepper_tb;

  localparam int unsigned NUM_ELEMENTS = 16;
  localparam logic [lps_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 4_000_000;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned RANDOM_ITEMS = 88;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned GAP_PCT [4] = '{0, 75, 0, 23};
  localparam int unsigned STALL_PCT [4] = '{0, 0, 75, 23};

  typedef struct packed {
    logic [lps_pkg::POS_W-1:0]   position;
    logic [lps_pkg::VALUE_W-1:0] element;
    logic                        last;
    logic                        wrapped;
  } emitted_t;

  typedef enum logic {ROW_REQUEST, ROW_CONFIG} row_kind_e;

  typedef struct packed {
    row_kind_e                      kind;
    logic [lps_pkg::OPCODE_W-1:0]   opcode;
    logic [lps_pkg::INDEX_W-1:0]    index;
    logic [lps_pkg::VALUE_W-1:0]    value;
    logic [lps_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [lps_pkg::CFG_DATA_W-1:0] reg_data;
    logic [lps_pkg::VALUE_W-1:0]    lead_element;
    logic                           lead_wrap;
  } stim_row_t;

  logic                           clk;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic [lps_pkg::OPCODE_W-1:0]   opcode = lps_pkg::OP_LOAD;
  logic [lps_pkg::INDEX_W-1:0]    index = '0;
  logic [lps_pkg::VALUE_W-1:0]    value = '0;
  logic                           out_ready = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [lps_pkg::CFG_IDX_W-1:0]  cfg_index = lps_pkg::CFG_SIZE_IN_USE;
  logic [lps_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           in_ready;
  logic                           out_valid;
  logic [lps_pkg::POS_W-1:0]      position;
  logic [lps_pkg::VALUE_W-1:0]    element;
  logic                           last;
  logic                           wrapped;

  logic [lps_pkg::VALUE_W-1:0] arr_m [NUM_ELEMENTS];
  logic                        wrap_m = 1'b0;
  logic [lps_pkg::SIZE_W-1:0]  size_m = lps_pkg::SIZE_RESET;
  logic [lps_pkg::EMIT_W-1:0]  emit_m = lps_pkg::EMIT_RESET;
  logic [lps_pkg::ADV_W-1:0]   steps_m = lps_pkg::ADVANCE_RESET;
  emitted_t                    prefix_due [$];

  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_request = 0;

  lexicographic_permutation_stepper dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .opcode_i    (opcode),
    .index_i     (index),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .position_o  (position),
    .element_o   (element),
    .last_o      (last),
    .wrapped_o   (wrapped),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void flag_error(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endfunction

  function automatic void reverse_span(int unsigned lo, int unsigned hi);
    logic [lps_pkg::VALUE_W-1:0] t;
    while (lo < hi) begin
      t = arr_m[lo];
      arr_m[lo] = arr_m[hi];
      arr_m[hi] = t;
      lo++;
      hi--;
    end
  endfunction

  // One step to the next arrangement of the first n elements; returns 1 when it wraps.
  function automatic bit next_order(int unsigned n);
    int unsigned p, q;
    logic [lps_pkg::VALUE_W-1:0] t;
    if (n < 2) return 1'b1;
    p = n - 1;
    while (p > 0 && arr_m[p-1] >= arr_m[p]) p--;
    if (p == 0) begin
      reverse_span(0, n - 1);
      return 1'b1;
    end
    p--;
    q = n - 1;
    while (arr_m[q] <= arr_m[p]) q--;
    t = arr_m[p];
    arr_m[p] = arr_m[q];
    arr_m[q] = t;
    reverse_span(p + 1, n - 1);
    return 1'b0;
  endfunction

  function automatic void predict_request(logic [lps_pkg::OPCODE_W-1:0] op,
                                          logic [lps_pkg::INDEX_W-1:0] idx,
                                          logic [lps_pkg::VALUE_W-1:0] val);
    int unsigned count, n;
    bit any_wrap;
    emitted_t r;
    if (op == lps_pkg::OP_LOAD) begin
      arr_m[idx] = val;
      return;
    end
    count = (emit_m == 0) ? 1 : (emit_m > NUM_ELEMENTS) ? NUM_ELEMENTS : emit_m;
    for (int unsigned k = 0; k < count; k++) begin
      r.position = k[lps_pkg::POS_W-1:0];
      r.element = arr_m[k];
      r.last = (k + 1 == count);
      r.wrapped = r.last && wrap_m;
      prefix_due.push_back(r);
    end
    n = (size_m > NUM_ELEMENTS) ? NUM_ELEMENTS : size_m;
    any_wrap = 1'b0;
    for (int unsigned k = 0; k < steps_m; k++) begin
      if (next_order(n)) any_wrap = 1'b1;
    end
    wrap_m = any_wrap;
  endfunction

  function automatic void predict_write(logic [lps_pkg::CFG_IDX_W-1:0] ri,
                                        logic [lps_pkg::CFG_DATA_W-1:0] d);
    case (ri)
      lps_pkg::CFG_SIZE_IN_USE:   size_m = d[lps_pkg::SIZE_W-1:0];
      lps_pkg::CFG_EMIT_COUNT:    emit_m = d[lps_pkg::EMIT_W-1:0];
      lps_pkg::CFG_ADVANCE_COUNT: steps_m = d[lps_pkg::ADV_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic stim_row_t load_row(logic [lps_pkg::INDEX_W-1:0] i,
                                         logic [lps_pkg::VALUE_W-1:0] v);
    stim_row_t r;
    r = '0;
    r.kind = ROW_REQUEST;
    r.opcode = lps_pkg::OP_LOAD;
    r.index = i;
    r.value = v;
    return r;
  endfunction

  function automatic stim_row_t advance_row(logic [lps_pkg::VALUE_W-1:0] lead, logic lw);
    stim_row_t r;
    r = '0;
    r.kind = ROW_REQUEST;
    r.opcode = lps_pkg::OP_ADVANCE;
    r.lead_element = lead;
    r.lead_wrap = lw;
    return r;
  endfunction

  function automatic stim_row_t config_row(logic [lps_pkg::CFG_IDX_W-1:0] ri,
                                           logic [lps_pkg::CFG_DATA_W-1:0] d);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CONFIG;
    r.reg_index = ri;
    r.reg_data = d;
    return r;
  endfunction

  task automatic write_reg(input logic [lps_pkg::CFG_IDX_W-1:0] ri,
                           input logic [lps_pkg::CFG_DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= ri;
    cfg_data <= d;
    @(posedge clk);
    predict_write(ri, d);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Returns at the edge that accepts the request, with valid still high.
  task automatic send_request(input logic [lps_pkg::OPCODE_W-1:0] op,
                              input logic [lps_pkg::INDEX_W-1:0] idx,
                              input logic [lps_pkg::VALUE_W-1:0] val,
                              output int unsigned first_slot);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    index <= idx;
    value <= val;
    do @(posedge clk); while (!in_ready);
    first_slot = prefix_due.size();
    predict_request(op, idx, val);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (prefix_due.size() != 0) @(posedge clk);
    while (!in_ready) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_random_settings();
    logic [lps_pkg::SIZE_W-1:0] sz;
    logic [lps_pkg::EMIT_W-1:0] em;
    logic [lps_pkg::ADV_W-1:0] st;
    logic [lps_pkg::CFG_DATA_W-lps_pkg::SIZE_W-1:0] pad;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) sz = lps_pkg::SIZE_W'($urandom_range(1, 0));
    else if (pick < 22) sz = lps_pkg::SIZE_W'($urandom_range(31, 17));
    else if (pick < 35) sz = 5'd16;
    else sz = lps_pkg::SIZE_W'($urandom_range(8, 2));
    pick = $urandom_range(99);
    if (pick < 10) em = '0;
    else if (pick < 20) em = lps_pkg::EMIT_W'($urandom_range(31, 17));
    else if (pick < 30) em = 5'd16;
    else em = lps_pkg::EMIT_W'($urandom_range(8, 1));
    pick = $urandom_range(99);
    if (pick < 8) st = '0;
    else if (pick < 16 && sz <= 4) st = lps_pkg::ADV_W'($urandom_range(300, 50));
    else st = lps_pkg::ADV_W'($urandom_range(4, 1));
    pad = (lps_pkg::CFG_DATA_W-lps_pkg::SIZE_W)'($urandom);
    write_reg(lps_pkg::CFG_SIZE_IN_USE, {pad, sz});
    pad = (lps_pkg::CFG_DATA_W-lps_pkg::SIZE_W)'($urandom);
    write_reg(lps_pkg::CFG_EMIT_COUNT, {pad, em});
    write_reg(lps_pkg::CFG_ADVANCE_COUNT, st);
  endtask

  task automatic send_random_request();
    logic [lps_pkg::OPCODE_W-1:0] op;
    logic [lps_pkg::INDEX_W-1:0] idx;
    logic [lps_pkg::VALUE_W-1:0] val;
    int unsigned slot;
    op = ($urandom_range(99) < 35) ? lps_pkg::OP_LOAD : lps_pkg::OP_ADVANCE;
    idx = lps_pkg::INDEX_W'($urandom);
    if ($urandom_range(1) != 0) val = lps_pkg::VALUE_W'($urandom_range(3));
    else val = lps_pkg::VALUE_W'($urandom);
    send_request(op, idx, val, slot);
  endtask

  initial begin
    int unsigned hold_len;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_len = hold_request;
        hold_request = 0;
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    emitted_t want;
    if (rst_n && out_valid && out_ready) begin
      if (prefix_due.size() == 0) begin
        flag_error($sformatf("unexpected result: position %0d element %02h last %b wrapped %b",
                             position, element, last, wrapped));
      end else begin
        want = prefix_due.pop_front();
        if (position !== want.position || element !== want.element ||
            last !== want.last || wrapped !== want.wrapped) begin
          flag_error($sformatf({"expected position %0d element %02h last %b wrapped %b, ",
                                "got position %0d element %02h last %b wrapped %b"},
                               want.position, want.element, want.last, want.wrapped,
                               position, element, last, wrapped));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    stim_row_t plan [$];
    stim_row_t row;
    emitted_t patched;
    int unsigned slot;

    // Every element is loaded before the first advance, so no unwritten element is ever read.
    plan.push_back(load_row(4'd0, 8'hFF));
    plan.push_back(load_row(4'd1, 8'h80));
    plan.push_back(load_row(4'd2, 8'h00));
    plan.push_back(load_row(4'd3, 8'h01));
    plan.push_back(load_row(4'd4, 8'hFE));
    plan.push_back(load_row(4'd5, 8'h55));
    plan.push_back(load_row(4'd6, 8'hAA));
    plan.push_back(load_row(4'd7, 8'h80));
    plan.push_back(load_row(4'd8, 8'h7F));
    plan.push_back(load_row(4'd9, 8'h01));
    plan.push_back(load_row(4'd10, 8'h33));
    plan.push_back(load_row(4'd11, 8'hCC));
    plan.push_back(load_row(4'd12, 8'h0F));
    plan.push_back(load_row(4'd13, 8'hF0));
    plan.push_back(load_row(4'd14, 8'h10));
    plan.push_back(load_row(4'd15, 8'h20));
    plan.push_back(advance_row(8'hFF, 1'b0));
    plan.push_back(config_row(lps_pkg::CFG_SIZE_IN_USE, 16'hFFE3));
    plan.push_back(config_row(lps_pkg::CFG_EMIT_COUNT, 16'h0000));
    plan.push_back(advance_row(8'hFF, 1'b0));
    plan.push_back(advance_row(8'h00, 1'b1));
    plan.push_back(config_row(lps_pkg::CFG_ADVANCE_COUNT, 16'h0000));
    plan.push_back(config_row(lps_pkg::CFG_EMIT_COUNT, 16'hFFFF));
    plan.push_back(advance_row(8'h00, 1'b0));
    plan.push_back(config_row(lps_pkg::CFG_SIZE_IN_USE, 16'h0000));
    plan.push_back(config_row(lps_pkg::CFG_ADVANCE_COUNT, 16'h0002));
    plan.push_back(advance_row(8'h00, 1'b0));
    plan.push_back(advance_row(8'h00, 1'b1));
    plan.push_back(config_row(lps_pkg::CFG_SIZE_IN_USE, 16'h0001));
    plan.push_back(config_row(lps_pkg::CFG_ADVANCE_COUNT, 16'hFFFF));
    plan.push_back(config_row(CFG_UNUSED, 16'hA5C3));
    plan.push_back(advance_row(8'h00, 1'b1));
    plan.push_back(config_row(lps_pkg::CFG_SIZE_IN_USE, 16'h001F));
    plan.push_back(config_row(lps_pkg::CFG_ADVANCE_COUNT, 16'h0001));
    plan.push_back(config_row(lps_pkg::CFG_EMIT_COUNT, 16'h0010));
    plan.push_back(advance_row(8'h00, 1'b1));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_CONFIG) begin
        wait_idle();
        write_reg(row.reg_index, row.reg_data);
      end else begin
        send_request(row.opcode, row.index, row.value, slot);
        if (row.opcode == lps_pkg::OP_ADVANCE) begin
          patched = prefix_due[slot];
          patched.element = row.lead_element;
          prefix_due[slot] = patched;
          patched = prefix_due[prefix_due.size() - 1];
          patched.wrapped = row.lead_wrap;
          prefix_due[prefix_due.size() - 1] = patched;
        end
      end
    end

    // Each phase drains fully before new settings; two phases open with a long receiver hold-off
    // so that pending requests back up against a full result path.
    for (int ph = 0; ph < 4; ph++) begin
      for (int half = 0; half < 2; half++) begin
        wait_idle();
        send_gap_pct = GAP_PCT[ph];
        stall_pct = STALL_PCT[ph];
        write_random_settings();
        if (half == 0 && (ph == 0 || ph == 3)) hold_request = HOLD_OFF_CYCLES;
        repeat (RANDOM_ITEMS / 8) send_random_request();
      end
    end

    wait_idle();
    if (mismatches == 0 && prefix_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
